### src/rtpjb_pkg.sv
// Package: shared types, codes and constants of the RTP jitter buffer.
package rtpjb_pkg;

   localparam int SLOT_COUNT_DEFAULT = 64;
   localparam logic [6:0] CNT_MAX = 7'd127;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_PULL  = 2'd1,
      OP_PEEK  = 2'd2,
      OP_FLUSH = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_STORED      = 4'd0,
      ST_STORED_LATE = 4'd1,
      ST_REPLACED    = 4'd2,
      ST_REJECTED    = 4'd3,
      ST_PULLED      = 4'd4,
      ST_NONE_READY  = 4'd5,
      ST_PEEK_FOUND  = 4'd6,
      ST_PEEK_EMPTY  = 4'd7,
      ST_FLUSHED     = 4'd8
   } status_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] seq_number;
      logic [31:0] packet_time;
      logic [15:0] packet_handle;
      logic [31:0] max_timestamp;
      logic        lock_to_timestamp;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] out_seq;
      logic [31:0] out_timestamp;
      logic [15:0] out_handle;
      logic        next_available;
      logic        evicted_valid;
      logic [15:0] evicted_handle;
      logic [6:0]  count_pending;
      logic [6:0]  count_late;
      logic [31:0] count_discarded;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_PUSH,
      S_SCAN,
      S_FETCH,
      S_FINISH,
      S_OUT
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load_req;
      logic rd_push;
      logic do_push;
      logic scan_clear;
      logic scan_step;
      logic rd_best;
      logic finish;
      logic do_flush;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic scan_last;
      logic is_push;
      logic is_flush;
   } stat_type;

   // a serially after b
   function automatic logic ser_after16(logic [15:0] a, logic [15:0] b);
      logic [15:0] d;
      d = a - b;
      return (d != 16'd0) && !d[15];
   endfunction

   function automatic logic ser_after32(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 32'd0) && !d[31];
   endfunction

   function automatic logic [6:0] inc_sat(logic [6:0] c);
      return (c < CNT_MAX) ? c + 7'd1 : c;
   endfunction

   function automatic logic [6:0] dec_sat(logic [6:0] c);
      return (c != 7'd0) ? c - 7'd1 : c;
   endfunction

endpackage

### src/rtp_jitter_buffer_top.sv
// Top level of the RTP jitter buffer: controller plus datapath.
// A table of SLOT_COUNT packet descriptors, each kept in slot seq mod SLOT_COUNT.
// One request is taken at a time. A push registers the request, reads the slot,
// then updates it. Pull and peek scan the slot memory one entry per cycle through
// its single read port, then read the chosen slot and finish; a flush clears the
// table at once. The result stays on rsp_ until it is taken, and the next request
// transfers in the cycle after that. Handles in the table are not freed on flush.
module rtp_jitter_buffer_top #(
   parameter int SLOT_COUNT = rtpjb_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rtpjb_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rtpjb_pkg::rsp_type rsp_data
);

   rtpjb_pkg::cmd_type  cmd;
   rtpjb_pkg::stat_type stat;

   // Sequence the steps of each request.
   rtpjb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the slots, counters and the result.
   rtpjb_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

### src/rtpjb_ctrl.sv
// Controller: sequences push, scan, pull, peek and flush steps.
module rtpjb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rtpjb_pkg::stat_type  stat,
   output rtpjb_pkg::cmd_type   cmd
);

   rtpjb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtpjb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         rtpjb_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req   = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in       = rtpjb_pkg::S_READ;
            end
         end
         rtpjb_pkg::S_READ: begin
            priority if (stat.is_flush) begin
               cmd.do_flush = 1'b1;
               state_in     = rtpjb_pkg::S_OUT;
            end else if (stat.is_push) begin
               cmd.rd_push = 1'b1;
               state_in    = rtpjb_pkg::S_PUSH;
            end else begin
               state_in = rtpjb_pkg::S_SCAN;
            end
         end
         rtpjb_pkg::S_PUSH: begin
            cmd.do_push = 1'b1;
            state_in    = rtpjb_pkg::S_OUT;
         end
         rtpjb_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = rtpjb_pkg::S_FETCH;
            end
         end
         rtpjb_pkg::S_FETCH: begin
            cmd.rd_best = 1'b1;
            state_in    = rtpjb_pkg::S_FINISH;
         end
         rtpjb_pkg::S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = rtpjb_pkg::S_OUT;
         end
         rtpjb_pkg::S_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = rtpjb_pkg::S_IDLE;
            end
         end
         default: state_in = rtpjb_pkg::S_IDLE;
      endcase
   end

endmodule

### src/rtpjb_datapath.sv
// Datapath: slot memory, occupancy bits, scan unit, counters and result register.
module rtpjb_datapath #(
   parameter int SLOT_COUNT = rtpjb_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  rtpjb_pkg::req_type  req_data,
   input  rtpjb_pkg::cmd_type  cmd,
   output rtpjb_pkg::stat_type stat,
   output rtpjb_pkg::rsp_type  rsp_data
);

   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int DW = 64;
   // Reciprocal for seq mod SLOT_COUNT, exact over all 16-bit sequence numbers.
   localparam int SH = 16 + IW;
   localparam logic [16:0] MUL =
      17'(((64'd1 << SH) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT));

   rtpjb_pkg::req_type req_ff;
   logic [DW-1:0]   mem [SLOT_COUNT];
   logic [DW-1:0]   rd_ff;
   logic [DW-1:0]   wr_data;
   logic [IW-1:0]   wr_idx;
   logic            wr_en;
   logic [IW-1:0]   rd_idx;
   logic            rd_en;
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;

   logic [IW-1:0]   scan_ff;
   logic [IW-1:0]   scan_d_ff;     // index of the data now in rd_ff
   logic            scan_rd_ff;    // rd_ff holds a scanned entry
   logic            found_ff;
   logic [IW-1:0]   best_ff;
   logic [15:0]     best_seq_ff;
   logic            scan_done_ff;

   logic [15:0]     mpull_ff, mpull_in;
   logic            first_ff, first_in;
   logic [6:0]      pend_ff, late_ff, pend_in, late_in;
   logic [31:0]     disc_ff, disc_in;
   rtpjb_pkg::rsp_type out_ff, out_in;

   logic [32:0]     idx_prod;
   logic [15:0]     idx_quot;
   logic [15:0]     idx_rem;
   logic [IW-1:0]   push_idx_ff, push_idx_in;
   logic [IW-1:0]   next_idx;
   logic            is_pull;
   logic            cand;
   logic [15:0]     rd_seq;

   assign next_idx = (best_ff == IW'(SLOT_COUNT - 1)) ? '0 : best_ff + IW'(1);
   assign is_pull  = (req_ff.operation == rtpjb_pkg::OP_PULL);
   assign rd_seq   = rd_ff[63:48];

   assign stat.scan_last = scan_done_ff;
   assign stat.is_push   = (req_ff.operation == rtpjb_pkg::OP_PUSH);
   assign stat.is_flush  = (req_ff.operation == rtpjb_pkg::OP_FLUSH);
   assign rsp_data       = out_ff;

   // Slot of the incoming sequence number.
   always_comb begin
      idx_prod    = 33'(req_data.seq_number) * 33'(MUL);
      idx_quot    = 16'(idx_prod >> SH);
      idx_rem     = req_data.seq_number - 16'(idx_quot * 16'(SLOT_COUNT));
      push_idx_in = idx_rem[IW-1:0];
   end

   // Read address: push slot, scan pointer or chosen slot.
   always_comb begin
      rd_en  = cmd.rd_push | cmd.scan_step | cmd.rd_best;
      rd_idx = cmd.rd_push ? push_idx_ff : (cmd.rd_best ? best_ff : scan_ff);
   end

   always_comb begin
      wr_en   = cmd.do_push && (!valid_ff[push_idx_ff] ||
                rtpjb_pkg::ser_after16(req_ff.seq_number, rd_seq));
      wr_idx  = push_idx_ff;
      wr_data = {req_ff.seq_number, req_ff.packet_time, req_ff.packet_handle};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff      <= req_data;
         push_idx_ff <= push_idx_in;
      end
   end

   // Candidate test on the entry read last cycle.
   always_comb begin
      cand = 1'b0;
      if (scan_rd_ff && valid_ff[scan_d_ff]) begin
         if (!found_ff) begin
            cand = 1'b1;
         end else if (is_pull) begin
            cand = rtpjb_pkg::ser_after16(best_seq_ff, rd_seq);
         end else begin
            cand = rd_seq < best_seq_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= '0;
         scan_rd_ff   <= 1'b0;
         scan_done_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else if (cmd.scan_clear) begin
         scan_ff      <= '0;
         scan_rd_ff   <= 1'b0;
         scan_done_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else if (cmd.scan_step || cmd.rd_best) begin
         if (cand) begin
            found_ff    <= 1'b1;
            best_ff     <= scan_d_ff;
            best_seq_ff <= rd_seq;
         end
         scan_d_ff  <= scan_ff;
         scan_rd_ff <= cmd.scan_step && !scan_done_ff;
         if (scan_ff == IW'(SLOT_COUNT - 1)) begin
            scan_done_ff <= 1'b1;
         end else begin
            scan_ff <= scan_ff + IW'(1);
         end
      end
   end

   // Slot state, counters and the result: next values.
   always_comb begin
      valid_in = valid_ff;
      first_in = first_ff;
      mpull_in = mpull_ff;
      pend_in  = pend_ff;
      late_in  = late_ff;
      disc_in  = disc_ff;
      out_in   = out_ff;
      priority if (cmd.do_flush) begin
         valid_in = '0;
         first_in = 1'b1;
         mpull_in = '0;
         pend_in  = '0;
         late_in  = '0;
         disc_in  = '0;
         out_in   = '0;
         out_in.status = rtpjb_pkg::ST_FLUSHED;
      end else if (cmd.do_push) begin
         out_in = '0;
         if (valid_ff[push_idx_ff]) begin
            disc_in = disc_ff + 32'd1;
            if (rtpjb_pkg::ser_after16(req_ff.seq_number, rd_seq)) begin
               // old entry before the mark and new one after it: move to pending
               if (!first_ff && (rd_seq != mpull_ff) &&
                   !rtpjb_pkg::ser_after16(rd_seq, mpull_ff) &&
                   rtpjb_pkg::ser_after16(req_ff.seq_number, mpull_ff)) begin
                  late_in = rtpjb_pkg::dec_sat(late_ff);
                  pend_in = rtpjb_pkg::inc_sat(pend_ff);
               end
               out_in.evicted_valid  = 1'b1;
               out_in.evicted_handle = rd_ff[15:0];
               out_in.status         = rtpjb_pkg::ST_REPLACED;
            end else begin
               out_in.status = rtpjb_pkg::ST_REJECTED;
            end
         end else begin
            valid_in[push_idx_ff] = 1'b1;
            if (!first_ff &&
                !rtpjb_pkg::ser_after16(req_ff.seq_number, mpull_ff)) begin
               late_in       = rtpjb_pkg::inc_sat(late_ff);
               out_in.status = rtpjb_pkg::ST_STORED_LATE;
            end else begin
               pend_in       = rtpjb_pkg::inc_sat(pend_ff);
               out_in.status = rtpjb_pkg::ST_STORED;
            end
         end
         out_in.count_pending   = pend_in;
         out_in.count_late      = late_in;
         out_in.count_discarded = disc_in;
      end else if (cmd.finish) begin
         out_in = '0;
         if (!is_pull) begin
            if (found_ff) begin
               out_in.status        = rtpjb_pkg::ST_PEEK_FOUND;
               out_in.out_seq       = rd_ff[63:48];
               out_in.out_timestamp = rd_ff[47:16];
            end else begin
               out_in.status = rtpjb_pkg::ST_PEEK_EMPTY;
            end
         end else if (!found_ff || (req_ff.lock_to_timestamp &&
                  rtpjb_pkg::ser_after32(rd_ff[47:16], req_ff.max_timestamp))) begin
            out_in.status = rtpjb_pkg::ST_NONE_READY;
         end else begin
            valid_in[best_ff] = 1'b0;
            if (first_ff || rtpjb_pkg::ser_after16(rd_seq, mpull_ff)) begin
               first_in = 1'b0;
               mpull_in = rd_seq;
               pend_in  = rtpjb_pkg::dec_sat(pend_ff);
            end else begin
               late_in = rtpjb_pkg::dec_sat(late_ff);
            end
            out_in.status         = rtpjb_pkg::ST_PULLED;
            out_in.out_seq        = rd_seq;
            out_in.out_timestamp  = rd_ff[47:16];
            out_in.out_handle     = rd_ff[15:0];
            out_in.next_available = (next_idx != best_ff) && valid_ff[next_idx];
         end
         out_in.count_pending   = pend_in;
         out_in.count_late      = late_in;
         out_in.count_discarded = disc_in;
      end else begin
         out_in = out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         first_ff <= 1'b1;
         mpull_ff <= '0;
         pend_ff  <= '0;
         late_ff  <= '0;
         disc_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         first_ff <= first_in;
         mpull_ff <= mpull_in;
         pend_ff  <= pend_in;
         late_ff  <= late_in;
         disc_ff  <= disc_in;
         out_ff   <= out_in;
      end
   end

endmodule

### verif/rtp_jitter_buffer_top_tb.sv
// Self-checking testbench for the RTP jitter buffer top level.
`timescale 1ns / 100ps

module rtp_jitter_buffer_top_tb;

   localparam int SLOTS = 64;
   localparam int RANDOM_ITEMS = 1850;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   rtpjb_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rtpjb_pkg::rsp_type rsp_data;

   rtp_jitter_buffer_top #(.SLOT_COUNT(SLOTS)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Shadow copy of the descriptor table and counters.
   logic        sh_valid [SLOTS];
   logic [15:0] sh_seq [SLOTS];
   logic [31:0] sh_time [SLOTS];
   logic [15:0] sh_handle [SLOTS];
   logic [15:0] sh_mark;
   logic        sh_no_pull;
   logic [6:0]  sh_pending;
   logic [6:0]  sh_late;
   logic [31:0] sh_discards;

   rtpjb_pkg::rsp_type expected_rsps[$];
   int      error_count = 0;
   bit      stimulus_done = 0;

   // Directed rows: request plus, where obvious, the typed-in result.
   typedef struct {
      rtpjb_pkg::req_type rq;
      bit                 has_fixed;
      rtpjb_pkg::rsp_type fixed;
   } dir_row_type;

   function automatic int ser_cmp16(logic [15:0] a, logic [15:0] b);
      logic [15:0] d;
      d = a - b;
      if (d == 16'd0) return 0;
      return d[15] ? -1 : 1;
   endfunction

   function automatic int ser_cmp32(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      if (d == 32'd0) return 0;
      return d[31] ? -1 : 1;
   endfunction

   function automatic logic [6:0] cnt_up(logic [6:0] c);
      return (c < 7'd127) ? c + 7'd1 : c;
   endfunction

   function automatic logic [6:0] cnt_down(logic [6:0] c);
      return (c != 7'd0) ? c - 7'd1 : c;
   endfunction

   function automatic void clear_shadow();
      for (int i = 0; i < SLOTS; i++) sh_valid[i] = 1'b0;
      sh_mark = '0;
      sh_no_pull = 1'b1;
      sh_pending = '0;
      sh_late = '0;
      sh_discards = '0;
   endfunction

   // Advance the shadow table by one request and return the buffer's answer.
   function automatic rtpjb_pkg::rsp_type jitter_outcome(rtpjb_pkg::req_type rq);
      rtpjb_pkg::rsp_type r;
      int idx, best;
      logic [15:0] old;
      r = '0;
      best = -1;
      case (rtpjb_pkg::op_type'(rq.operation))
         rtpjb_pkg::OP_PUSH: begin
            idx = rq.seq_number % SLOTS;
            if (sh_valid[idx]) begin
               old = sh_seq[idx];
               sh_discards++;
               if (ser_cmp16(rq.seq_number, old) > 0) begin
                  if (!sh_no_pull && ser_cmp16(old, sh_mark) < 0 &&
                      ser_cmp16(rq.seq_number, sh_mark) > 0) begin
                     sh_late = cnt_down(sh_late);
                     sh_pending = cnt_up(sh_pending);
                  end
                  r.evicted_valid = 1'b1;
                  r.evicted_handle = sh_handle[idx];
                  sh_seq[idx] = rq.seq_number;
                  sh_time[idx] = rq.packet_time;
                  sh_handle[idx] = rq.packet_handle;
                  r.status = rtpjb_pkg::ST_REPLACED;
               end else begin
                  r.status = rtpjb_pkg::ST_REJECTED;
               end
            end else begin
               if (!sh_no_pull && ser_cmp16(rq.seq_number, sh_mark) <= 0) begin
                  sh_late = cnt_up(sh_late);
                  r.status = rtpjb_pkg::ST_STORED_LATE;
               end else begin
                  sh_pending = cnt_up(sh_pending);
                  r.status = rtpjb_pkg::ST_STORED;
               end
               sh_valid[idx] = 1'b1;
               sh_seq[idx] = rq.seq_number;
               sh_time[idx] = rq.packet_time;
               sh_handle[idx] = rq.packet_handle;
            end
         end
         rtpjb_pkg::OP_PULL: begin
            for (int i = 0; i < SLOTS; i++)
               if (sh_valid[i] && (best < 0 || ser_cmp16(sh_seq[best], sh_seq[i]) > 0))
                  best = i;
            if (best < 0 || (rq.lock_to_timestamp &&
                             ser_cmp32(sh_time[best], rq.max_timestamp) > 0)) begin
               r.status = rtpjb_pkg::ST_NONE_READY;
            end else begin
               sh_valid[best] = 1'b0;
               if (sh_no_pull) begin
                  sh_no_pull = 1'b0;
                  sh_mark = sh_seq[best];
                  sh_pending = cnt_down(sh_pending);
               end else if (ser_cmp16(sh_seq[best], sh_mark) <= 0) begin
                  sh_late = cnt_down(sh_late);
               end else begin
                  sh_mark = sh_seq[best];
                  sh_pending = cnt_down(sh_pending);
               end
               r.status = rtpjb_pkg::ST_PULLED;
               r.out_seq = sh_seq[best];
               r.out_timestamp = sh_time[best];
               r.out_handle = sh_handle[best];
               r.next_available = sh_valid[(best + 1) % SLOTS];
            end
         end
         rtpjb_pkg::OP_PEEK: begin
            for (int i = 0; i < SLOTS; i++)
               if (sh_valid[i] && (best < 0 || sh_seq[i] < sh_seq[best])) best = i;
            if (best < 0) begin
               r.status = rtpjb_pkg::ST_PEEK_EMPTY;
            end else begin
               r.status = rtpjb_pkg::ST_PEEK_FOUND;
               r.out_seq = sh_seq[best];
               r.out_timestamp = sh_time[best];
            end
         end
         default: begin
            clear_shadow();
            r.status = rtpjb_pkg::ST_FLUSHED;
         end
      endcase
      r.count_pending = sh_pending;
      r.count_late = sh_late;
      r.count_discarded = sh_discards;
      return r;
   endfunction

   function automatic rtpjb_pkg::req_type make_req(rtpjb_pkg::op_type op,
                                                   logic [15:0] seq, logic [31:0] ts,
                                                   logic [15:0] hd, logic [31:0] lim,
                                                   logic lk);
      rtpjb_pkg::req_type rq;
      rq.operation = op;
      rq.seq_number = seq;
      rq.packet_time = ts;
      rq.packet_handle = hd;
      rq.max_timestamp = lim;
      rq.lock_to_timestamp = lk;
      return rq;
   endfunction

   // Clock and the overall time limit.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: stall on its own rhythm, with quiet spells where it never stalls.
   initial begin
      int mode;
      rsp_stall = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(20, 200)) begin
            @(posedge clock);
            if (mode == 0) rsp_stall <= 1'b0;
            else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
            else rsp_stall <= ($urandom_range(0, 9) < 7);
         end
      end
   end

   // Check every result transfer against the oldest outstanding prediction.
   always @(posedge clock) begin
      rtpjb_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: result mismatch, expected %p, actual %p",
                        $time, want, rsp_data);
               error_count++;
            end
         end
      end
   end

   // Offer one request, hold it until it transfers, then predict its result.
   task automatic send_req(rtpjb_pkg::req_type rq, bit has_fixed,
                           rtpjb_pkg::rsp_type fixed);
      rtpjb_pkg::rsp_type r;
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (req_stall);
      r = jitter_outcome(rq);
      if (has_fixed && r !== fixed) begin
         $display("%0t: typed-in result disagrees, expected %p, actual %p",
                  $time, fixed, r);
         error_count++;
      end
      expected_rsps.push_back(has_fixed ? fixed : r);
   endtask

   // Drop valid now and then, so gaps fall between transfers.
   task automatic maybe_gap(ref int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clock);
      burst_left = $urandom_range(0, 15);
   endtask

   initial begin
      dir_row_type rows[$];
      dir_row_type row;
      rtpjb_pkg::rsp_type none;
      rtpjb_pkg::req_type rq;
      logic [15:0] base;
      int burst_left, pick;
      none = '0;
      req_valid = 1'b0;
      req_data = '0;
      reset = 1'b1;
      clear_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty cases, field extremes, serial wrap, lock hold, flush.
      row.has_fixed = 1;
      row.fixed = '0; row.fixed.status = rtpjb_pkg::ST_NONE_READY;
      row.rq = make_req(rtpjb_pkg::OP_PULL, '1, '1, '1, '1, 1'b1); rows.push_back(row);
      row.fixed.status = rtpjb_pkg::ST_PEEK_EMPTY;
      row.rq = make_req(rtpjb_pkg::OP_PEEK, '1, '1, '1, '1, 1'b1); rows.push_back(row);
      row.fixed = '0; row.fixed.status = rtpjb_pkg::ST_STORED;
      row.fixed.count_pending = 7'd1;
      row.rq = make_req(rtpjb_pkg::OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, '0, 1'b0);
      rows.push_back(row);
      row.has_fixed = 0;
      row.rq = make_req(rtpjb_pkg::OP_PUSH, 16'h0000, 32'h0, 16'h0, '1, 1'b1);
      rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PUSH, 16'h0040, 32'h10, 16'h1234, '0, 1'b0);
      rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PUSH, 16'h0000, 32'h20, 16'h5555, '0, 1'b0);
      rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PUSH, 16'h8040, 32'h30, 16'hAAAA, '0, 1'b0);
      rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PEEK, '0, '0, '0, '0, 1'b0); rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PULL, '0, '0, '0, 32'h7FFF_FFFF, 1'b1);
      rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PULL, '0, '0, '0, '0, 1'b0); rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PUSH, 16'hFFFE, 32'h5, 16'h0BAD, '0, 1'b0);
      rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PUSH, 16'h0001, 32'h40, 16'h0101, '0, 1'b0);
      rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PUSH, 16'h0002, 32'h8000_0000, 16'h0202, '0, 1'b0);
      rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PULL, '0, '0, '0, '0, 1'b1); rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PULL, '0, '0, '0, '0, 1'b0); rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PULL, '0, '0, '0, 32'h40, 1'b1); rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PULL, '0, '0, '0, 32'h40, 1'b1); rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PUSH, 16'h0041, 32'h1, 16'h0303, '0, 1'b0);
      rows.push_back(row);
      row.rq = make_req(rtpjb_pkg::OP_PULL, '0, '0, '0, '0, 1'b0); rows.push_back(row);
      row.has_fixed = 1; row.fixed = '0; row.fixed.status = rtpjb_pkg::ST_FLUSHED;
      row.rq = make_req(rtpjb_pkg::OP_FLUSH, '1, '1, '1, '1, 1'b1); rows.push_back(row);
      row.fixed.status = rtpjb_pkg::ST_PEEK_EMPTY;
      row.rq = make_req(rtpjb_pkg::OP_PEEK, '0, '0, '0, '0, 1'b0); rows.push_back(row);

      burst_left = 0;
      foreach (rows[i]) begin
         send_req(rows[i].rq, rows[i].has_fixed, rows[i].fixed);
         maybe_gap(burst_left);
      end

      // Random: mostly realistic streams around a moving base, with reordering,
      // duplicates and occasional wild numbers; flush rarely to restart.
      base = 16'($urandom);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         rq = '0;
         rq.seq_number = 16'($urandom);
         rq.packet_time = $urandom;
         rq.packet_handle = 16'($urandom);
         rq.max_timestamp = $urandom;
         rq.lock_to_timestamp = 1'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            rq.operation = rtpjb_pkg::OP_PUSH;
            if ($urandom_range(0, 9) != 0) begin
               rq.seq_number = base + 16'($urandom_range(0, 80)) - 16'd16;
               rq.packet_time = {rq.seq_number, 16'h0} + 32'($urandom_range(0, 3));
            end
            if ($urandom_range(0, 3) == 0) base += 16'($urandom_range(1, 6));
         end else if (pick < 85) begin
            rq.operation = rtpjb_pkg::OP_PULL;
            if ($urandom_range(0, 1) == 0)
               rq.max_timestamp = {base, 16'h0} + 32'($urandom_range(0, 1 << 20));
         end else if (pick < 98) begin
            rq.operation = rtpjb_pkg::OP_PEEK;
         end else begin
            rq.operation = rtpjb_pkg::OP_FLUSH;
            base = 16'($urandom);
         end
         send_req(rq, 0, none);
         maybe_gap(burst_left);
      end
      req_valid <= 1'b0;
      stimulus_done = 1;
   end

   // Drain and report.
   initial begin
      wait (stimulus_done);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SLOTS + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### filelist.f
src/rtpjb_pkg.sv
src/rtpjb_ctrl.sv
src/rtpjb_datapath.sv
src/rtp_jitter_buffer_top.sv
verif/rtp_jitter_buffer_top_tb.sv
